// ----- src/cfe_pkg.sv -----
`timescale 1ns / 1ps
// cfe_pkg: shared types and constants of the clipped span fill engine
// (beat structs, command codes, fill plan types); depends on nothing
package cfe_pkg;

  localparam int WIDTH   = 256;
  localparam int HEIGHT  = 256;
  localparam int PIXELS  = WIDTH * HEIGHT;
  localparam int AW      = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int XW      = $clog2(WIDTH + 1);
  localparam int YW      = $clog2(HEIGHT + 1);
  localparam int COUNT_W = 17;
  localparam int NSEG    = 4;
  localparam int SEG_W   = $clog2(NSEG);

  localparam logic [31:0] RESET_PIXEL = 32'hff222020;

  typedef enum logic [2:0] {
    CMD_CLEAR   = 3'd0,
    CMD_HSPAN   = 3'd1,
    CMD_VSPAN   = 3'd2,
    CMD_FILL    = 3'd3,
    CMD_OUTLINE = 3'd4,
    CMD_READ    = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [15:0] x_start;
    logic signed [15:0] x_end;
    logic signed [15:0] y_start;
    logic signed [15:0] y_end;
    logic [31:0]        color;
  } in_t;

  typedef struct packed {
    logic [31:0]        read_color;
    logic [COUNT_W-1:0] pixels_written;
  } out_t;

  // one clipped rectangle [xa,xb) x [ya,yb)
  typedef struct packed {
    logic          en;
    logic [XW-1:0] xa;
    logic [XW-1:0] xb;
    logic [YW-1:0] ya;
    logic [YW-1:0] yb;
  } seg_t;

  typedef struct packed {
    seg_t [NSEG-1:0] seg;
    logic            corr;
    logic            rd;
  } plan_t;

  typedef struct packed {
    logic          we;
    logic          re;
    logic [AW-1:0] addr;
    logic [31:0]   wdata;
  } mem_req_t;

  function automatic plan_t clear_plan();
    plan_t p;
    p = '0;
    p.seg[0].en = 1'b1;
    p.seg[0].xa = '0;
    p.seg[0].xb = XW'(WIDTH);
    p.seg[0].ya = '0;
    p.seg[0].yb = YW'(HEIGHT);
    return p;
  endfunction

endpackage

// ----- src/cfe_frame_mem.sv -----
`timescale 1ns / 1ps
// cfe_frame_mem: pixel store, one request port (shared address) for writes and reads, registered read data
// depends on cfe_pkg
module cfe_frame_mem (
  input  logic              clk,
  input  cfe_pkg::mem_req_t req,
  output logic [31:0]       rdata
);

  logic [31:0] store_r [cfe_pkg::PIXELS];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      store_r[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= store_r[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/cfe_decode.sv -----
`timescale 1ns / 1ps
// cfe_decode: orders, clips and clamps one command into up to four rectangles
// depends on cfe_pkg
module cfe_decode (
  input  cfe_pkg::in_t   in_item,
  output cfe_pkg::plan_t plan
);

  localparam logic signed [15:0] WLIM = 16'(cfe_pkg::WIDTH);
  localparam logic signed [15:0] HLIM = 16'(cfe_pkg::HEIGHT);
  localparam logic signed [15:0] ONE  = 16'sd1;

  function automatic logic [15:0] clampc(logic signed [15:0] v, logic signed [15:0] hi);
    logic [15:0] r;
    if (v < 16'sd0) r = '0;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic cfe_pkg::seg_t mk(logic en, logic [15:0] xa, logic [15:0] xb,
                                       logic [15:0] ya, logic [15:0] yb);
    cfe_pkg::seg_t s;
    s.xa = xa[cfe_pkg::XW-1:0];
    s.xb = xb[cfe_pkg::XW-1:0];
    s.ya = ya[cfe_pkg::YW-1:0];
    s.yb = yb[cfe_pkg::YW-1:0];
    s.en = en && (s.xa < s.xb) && (s.ya < s.yb);
    return s;
  endfunction

  logic signed [15:0] lx, hx, ly, hy;
  logic [15:0]        cxa, cxb, cya, cyb;
  logic               overlap, x_in, y_in, left, top;

  always_comb begin
    lx = (in_item.x_end < in_item.x_start) ? in_item.x_end : in_item.x_start;
    hx = (in_item.x_end < in_item.x_start) ? in_item.x_start : in_item.x_end;
    ly = (in_item.y_end < in_item.y_start) ? in_item.y_end : in_item.y_start;
    hy = (in_item.y_end < in_item.y_start) ? in_item.y_start : in_item.y_end;
    cxa = clampc(lx, WLIM);
    cxb = clampc(hx, WLIM);
    cya = clampc(ly, HLIM);
    cyb = clampc(hy, HLIM);
    x_in = (in_item.x_start >= 16'sd0) && (in_item.x_start < WLIM);
    y_in = (in_item.y_start >= 16'sd0) && (in_item.y_start < HLIM);
    overlap = (lx < WLIM) && (hx >= 16'sd0) && (ly < HLIM) && (hy >= 16'sd0);
    left = lx >= 16'sd0;
    top  = ly >= 16'sd0;

    plan = '0;
    case (in_item.command)
      cfe_pkg::CMD_CLEAR: begin
        plan = cfe_pkg::clear_plan();
      end
      cfe_pkg::CMD_HSPAN: begin
        plan.seg[0] = mk(y_in, cxa, cxb, in_item.y_start, in_item.y_start + ONE);
      end
      cfe_pkg::CMD_VSPAN: begin
        plan.seg[0] = mk(x_in, in_item.x_start, in_item.x_start + ONE, cya, cyb);
      end
      cfe_pkg::CMD_FILL: begin
        plan.seg[0] = mk(overlap, cxa, cxb, cya, cyb);
      end
      cfe_pkg::CMD_OUTLINE: begin
        plan.seg[0] = mk(overlap && left, lx, lx + ONE, cya, cyb);
        plan.seg[1] = mk(overlap && (hx < WLIM) && (hx != lx), hx, hx + ONE, cya, cyb);
        plan.seg[2] = mk(overlap && top, cxa, cxb, ly, ly + ONE);
        plan.seg[3] = mk(overlap && (hy < HLIM) && (hy != ly), cxa, cxb, hy, hy + ONE);
        plan.corr   = overlap && left && top && (lx < hx) && (ly < hy);
      end
      cfe_pkg::CMD_READ: begin
        plan.seg[0] = mk(x_in && y_in, in_item.x_start, in_item.x_start + ONE,
                         in_item.y_start, in_item.y_start + ONE);
        plan.rd     = 1'b1;
      end
      default: begin
        plan = '0;
      end
    endcase
  end

endmodule

// ----- src/cfe_sweep.sv -----
`timescale 1ns / 1ps
// cfe_sweep: sequencer that walks the planned rectangles over the pixel store,
// counts writes, performs pixel reads and issues the result beat; depends on cfe_pkg
module cfe_sweep (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cfe_pkg::plan_t    plan,
  input  logic [31:0]       color,
  input  logic [31:0]       mem_rdata,
  output cfe_pkg::mem_req_t mem_req,
  output logic              busy,
  output logic              out_valid,
  output cfe_pkg::out_t     out_item
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_RUN,
    S_RD,
    S_RDW,
    S_DONE
  } state_t;

  localparam logic [cfe_pkg::SEG_W-1:0] LAST_SEG = cfe_pkg::SEG_W'(cfe_pkg::NSEG - 1);
  localparam logic [cfe_pkg::AW-1:0]    ROW_STEP = cfe_pkg::AW'(cfe_pkg::WIDTH);

  state_t                        state_r;
  cfe_pkg::plan_t                plan_r;
  logic [31:0]                   color_r;
  logic [cfe_pkg::SEG_W-1:0]     seg_r;
  logic [cfe_pkg::XW-1:0]        x_r;
  logic [cfe_pkg::YW-1:0]        y_r;
  logic [cfe_pkg::AW-1:0]        addr_r;
  logic [cfe_pkg::AW-1:0]        row_r;
  logic [cfe_pkg::COUNT_W-1:0]   cnt_r;
  logic [31:0]                   rd_r;
  logic                          quiet_r;
  logic                          out_valid_r;
  cfe_pkg::out_t                 out_r;

  cfe_pkg::seg_t                 cur;
  logic [cfe_pkg::AW-1:0]        base;
  logic                          x_last, y_last;

  always_comb begin
    cur    = plan_r.seg[seg_r];
    base   = cfe_pkg::AW'(cur.ya) * ROW_STEP + cfe_pkg::AW'(cur.xa);
    x_last = ({1'b0, x_r} + (cfe_pkg::XW + 1)'(1)) == {1'b0, cur.xb};
    y_last = ({1'b0, y_r} + (cfe_pkg::YW + 1)'(1)) == {1'b0, cur.yb};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SETUP;
      plan_r      <= cfe_pkg::clear_plan();
      color_r     <= cfe_pkg::RESET_PIXEL;
      seg_r       <= '0;
      cnt_r       <= '0;
      rd_r        <= '0;
      quiet_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            plan_r  <= plan;
            color_r <= color;
            seg_r   <= '0;
            cnt_r   <= '0;
            rd_r    <= '0;
            quiet_r <= 1'b0;
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (cur.en) begin
            x_r     <= cur.xa;
            y_r     <= cur.ya;
            addr_r  <= base;
            row_r   <= base;
            state_r <= plan_r.rd ? S_RD : S_RUN;
          end else if (seg_r == LAST_SEG) begin
            state_r <= S_DONE;
          end else begin
            seg_r <= seg_r + cfe_pkg::SEG_W'(1);
          end
        end
        S_RUN: begin
          cnt_r <= cnt_r + cfe_pkg::COUNT_W'(1);
          if (x_last) begin
            if (y_last) begin
              if (seg_r == LAST_SEG) begin
                state_r <= S_DONE;
              end else begin
                seg_r   <= seg_r + cfe_pkg::SEG_W'(1);
                state_r <= S_SETUP;
              end
            end else begin
              y_r    <= y_r + cfe_pkg::YW'(1);
              x_r    <= cur.xa;
              row_r  <= row_r + ROW_STEP;
              addr_r <= row_r + ROW_STEP;
            end
          end else begin
            x_r    <= x_r + cfe_pkg::XW'(1);
            addr_r <= addr_r + cfe_pkg::AW'(1);
          end
        end
        S_RD: begin
          state_r <= S_RDW;
        end
        S_RDW: begin
          rd_r    <= mem_rdata;
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid_r             <= !quiet_r;
          out_r.read_color        <= rd_r;
          out_r.pixels_written    <= cnt_r - cfe_pkg::COUNT_W'(plan_r.corr);
          state_r                 <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    mem_req.we    = state_r == S_RUN;
    mem_req.re    = state_r == S_RD;
    mem_req.addr  = addr_r;
    mem_req.wdata = color_r;
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_addr_tracks_xy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |->
      addr_r == cfe_pkg::AW'(y_r) * ROW_STEP + cfe_pkg::AW'(x_r))
    else $error("write address does not match pixel coordinates");

  a_walk_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> (cur.en && x_r < cur.xb && y_r < cur.yb))
    else $error("pixel walk left its rectangle");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> !plan_r.rd)
    else $error("store written during a pixel read");

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_DONE))
    else $error("result beat without a finished command");

endmodule

// ----- src/clipped_span_fill_engine.sv -----
`timescale 1ns / 1ps
// clipped_span_fill_engine: top level of the 2D span and rectangle fill engine
// depends on cfe_pkg, cfe_decode, cfe_sweep, cfe_frame_mem
//
// Usage: a command beat (in_item) is taken at a clock edge with start high and
// busy low. Commands: clear, horizontal span, vertical span, filled rectangle,
// rectangle outline, pixel read. Every command gives exactly one result beat on
// out_item, marked by out_valid for one cycle; the receiver cannot stall it.
// Timing: a write command walks up to four clipped rectangles, one pixel per
// cycle through the single write port of the pixel store, with one setup state
// per rectangle slot; a clear writes all 65536 pixels. A pixel read passes
// through address setup, a registered store read and capture.
// busy falls together with out_valid, so the next command may be given in the
// cycle the result is shown.
// Reset: after rst_n is released the engine runs a clearing pass that writes
// the reset color to every pixel, with busy high and no result beat.
module clipped_span_fill_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  cfe_pkg::in_t   in_item,
  output logic           out_valid,
  output cfe_pkg::out_t  out_item
);

  cfe_pkg::plan_t    plan;
  cfe_pkg::mem_req_t mem_req;
  logic [31:0]       mem_rdata;

  cfe_decode u_decode (
    .in_item (in_item),
    .plan    (plan)
  );

  cfe_sweep u_sweep (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .plan      (plan),
    .color     (in_item.color),
    .mem_rdata (mem_rdata),
    .mem_req   (mem_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  cfe_frame_mem u_frame_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule
